// File: rtl/prtm_pkg.sv
// ----------------------------------------------------------------------------
// prtm_pkg: shared types and constants of the periodic timer
// Command, rearm mode, register index and sequencer state codes, reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package prtm_pkg;

    localparam int TIME_WIDTH_DEF = 48;
    localparam int CFG_WIDTH      = 32;
    localparam int PERIOD_WIDTH   = 32;
    localparam int COUNT_WIDTH    = 32;
    localparam int CFG_IDX_WIDTH  = 2;

    localparam logic [PERIOD_WIDTH-1:0] PERIOD_RESET = 32'd1000;
    localparam logic [COUNT_WIDTH-1:0]  COUNT_RESET  = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        CMD_POLL  = 2'd0,
        CMD_START = 2'd1,
        CMD_STOP  = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        MODE_STRICT = 2'd0,
        MODE_SKIP   = 2'd1,
        MODE_CONT   = 2'd2
    } mode_t;

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        REG_MODE   = 2'd0,
        REG_PERIOD = 2'd1,
        REG_COUNT  = 2'd2
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMP,
        ST_DIV,
        ST_SUBR,
        ST_ADD,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

// File: rtl/prtm_arith.sv
// ----------------------------------------------------------------------------
// prtm_arith: shared add/subtract unit
// One AW-bit adder used for compares, remainder steps and deadline sums.
// The top bit of res is the carry of an add or the borrow of a subtract.
// ----------------------------------------------------------------------------
`default_nettype none

module prtm_arith #(
    parameter int AW = 49
) (
    input  wire logic [AW-1:0] a,
    input  wire logic [AW-1:0] b,
    input  wire logic          sub,
    output logic      [AW:0]   res
);
    logic [AW:0] ax;
    logic [AW:0] bx;

    assign ax  = {1'b0, a};
    assign bx  = {1'b0, b};
    assign res = sub ? (ax - bx) : (ax + bx);

endmodule

`default_nettype wire

// File: rtl/periodic_timer_rearm_modes.sv
// ----------------------------------------------------------------------------
// periodic_timer_rearm_modes: periodic timer with repeat count
// Start / stop / poll commands with the current time; rearms in strict, skip
// or continue mode, counts events down and saturates deadlines.
//
//   channel   direction  handshake              word
//   in        sink       in_valid / in_stall    command, now_ms
//   out       source     out_valid / out_stall  ok, fired, next_deadline, running
//   cfg       sink       cfg_we                 cfg_index, cfg_data
//
// Stop and an unused command go from accept straight to DONE; start passes
// through ADD; an unfiring poll and a skip poll with nothing to step through
// CMP; a firing strict or continue poll through CMP and ADD. A firing skip
// poll passes through CMP, DIV, SUBR and ADD: the remainder of the elapsed
// time by the period comes from one shared adder, one bit a cycle.
// in_stall is high from accept until the result moves to the output register.
// A held output stalls only the final step; reset stops the timer.
// ----------------------------------------------------------------------------
`default_nettype none

module periodic_timer_rearm_modes
#(
    parameter int TIME_WIDTH = prtm_pkg::TIME_WIDTH_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [prtm_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
    input  wire logic [prtm_pkg::CFG_WIDTH-1:0]     cfg_data,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic [1:0]                         command,
    input  wire logic [TIME_WIDTH-1:0]              now_ms,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic                                    ok,
    output logic                                    fired,
    output logic      [TIME_WIDTH-1:0]              next_deadline,
    output logic                                    running
);
    import prtm_pkg::*;

    localparam int AW   = ((TIME_WIDTH > PERIOD_WIDTH) ? TIME_WIDTH : PERIOD_WIDTH) + 1;
    localparam int CNTW = $clog2(TIME_WIDTH + 1);

    // configuration
    logic [1:0]              mode_reg;
    logic [PERIOD_WIDTH-1:0] period_cfg_reg;
    logic [COUNT_WIDTH-1:0]  count_cfg_reg;

    // timer state
    state_t                  state_reg, state_next;
    logic                    running_reg, running_next;
    logic [TIME_WIDTH-1:0]   deadline_reg, deadline_next;
    logic [PERIOD_WIDTH-1:0] period_reg, period_next;
    logic [COUNT_WIDTH-1:0]  remain_reg, remain_next;

    // per-word work registers
    cmd_t                    cmd_reg, cmd_next;
    logic [TIME_WIDTH-1:0]   now_reg, now_next;
    logic                    fire_reg, fire_next;
    logic                    base_dl_reg, base_dl_next;
    logic                    use_rem_reg, use_rem_next;
    logic [TIME_WIDTH-1:0]   dvd_reg, dvd_next;
    logic [AW-1:0]           rem_reg, rem_next;
    logic [CNTW-1:0]         cnt_reg, cnt_next;

    // output register
    logic                    out_valid_reg, out_valid_next;
    logic                    ok_reg, ok_next;
    logic                    fired_reg, fired_next;
    logic [TIME_WIDTH-1:0]   nd_reg, nd_next;
    logic                    run_out_reg, run_out_next;

    // shared unit
    logic [AW-1:0]           alu_a, alu_b;
    logic                    alu_sub;
    logic [AW:0]             alu_res;

    logic                    accept;
    logic                    out_free;
    logic                    borrow;
    logic                    fire_now;
    logic [TIME_WIDTH-1:0]   sat_sum;
    logic [TIME_WIDTH-1:0]   elapsed;
    logic [AW-1:0]           rem_shift;
    logic [AW-1:0]           now_x, dl_x, per_x;
    logic [COUNT_WIDTH-1:0]  remain_after;
    logic                    run_after;

    prtm_arith #(
        .AW (AW)
    ) u_arith (
        .a   (alu_a),
        .b   (alu_b),
        .sub (alu_sub),
        .res (alu_res)
    );

    assign accept    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != ST_IDLE);

    assign now_x     = {{(AW-TIME_WIDTH){1'b0}}, now_reg};
    assign dl_x      = {{(AW-TIME_WIDTH){1'b0}}, deadline_reg};
    assign per_x     = {{(AW-PERIOD_WIDTH){1'b0}}, period_reg};
    assign rem_shift = {rem_reg[AW-2:0], dvd_reg[TIME_WIDTH-1]};

    assign borrow    = alu_res[AW];
    assign elapsed   = alu_res[TIME_WIDTH-1:0];
    // clamp any sum that leaves the time range to all ones
    assign sat_sum   = (alu_res[AW:TIME_WIDTH] != '0) ? '1 : alu_res[TIME_WIDTH-1:0];
    assign fire_now  = (cmd_reg == CMD_POLL) && running_reg && !borrow;

    // event count: positive counts step down, negative ones hold
    assign remain_after = (fire_reg && (remain_reg != '0) && !remain_reg[COUNT_WIDTH-1])
                        ? remain_reg - COUNT_WIDTH'(1) : remain_reg;

    always_comb
    begin
        unique case (cmd_reg)
            CMD_START: run_after = 1'b1;
            CMD_STOP:  run_after = 1'b0;
            default:   run_after = fire_reg ? (remain_after != '0) : running_reg;
        endcase
    end

    // shared unit operands
    always_comb
    begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        unique case (state_reg)
            ST_CMP:
            begin
                alu_a   = now_x;
                alu_b   = dl_x;
                alu_sub = 1'b1;
            end
            ST_DIV:
            begin
                alu_a   = rem_shift;
                alu_b   = per_x;
                alu_sub = 1'b1;
            end
            ST_SUBR:
            begin
                alu_a   = per_x;
                alu_b   = rem_reg;
                alu_sub = 1'b1;
            end
            ST_ADD:
            begin
                alu_a   = base_dl_reg ? dl_x : now_x;
                alu_b   = use_rem_reg ? rem_reg : per_x;
            end
            default:
            begin
                alu_a   = '0;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (command)
                        CMD_POLL:  state_next = ST_CMP;
                        CMD_START: state_next = ST_ADD;
                        default:   state_next = ST_DONE;
                    endcase
                end
            end
            ST_CMP:
            begin
                if (!fire_now)
                    state_next = ST_DONE;
                else
                begin
                    unique case (mode_reg)
                        MODE_SKIP:
                        begin
                            if ((period_reg == '0) || (elapsed == '0))
                                state_next = ST_DONE;
                            else
                                state_next = ST_DIV;
                        end
                        default: state_next = ST_ADD;
                    endcase
                end
            end
            ST_DIV:
            begin
                if (cnt_reg == CNTW'(1))
                    state_next = ST_SUBR;
            end
            ST_SUBR: state_next = ST_ADD;
            ST_ADD:  state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        running_next   = running_reg;
        deadline_next  = deadline_reg;
        period_next    = period_reg;
        remain_next    = remain_reg;
        cmd_next       = cmd_reg;
        now_next       = now_reg;
        fire_next      = fire_reg;
        base_dl_next   = base_dl_reg;
        use_rem_next   = use_rem_reg;
        dvd_next       = dvd_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        ok_next        = ok_reg;
        fired_next     = fired_reg;
        nd_next        = nd_reg;
        run_out_next   = run_out_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_next     = cmd_t'(command);
                    now_next     = now_ms;
                    fire_next    = 1'b0;
                    base_dl_next = 1'b0;
                    use_rem_next = 1'b0;
                    if (command == CMD_START)
                    begin
                        period_next = period_cfg_reg;
                        remain_next = count_cfg_reg;
                    end
                end
            end
            ST_CMP:
            begin
                fire_next    = fire_now;
                dvd_next     = elapsed;
                rem_next     = '0;
                cnt_next     = CNTW'(TIME_WIDTH);
                base_dl_next = (mode_reg != MODE_SKIP) && (mode_reg != MODE_CONT);
                use_rem_next = 1'b0;
            end
            ST_DIV:
            begin
                // restoring step: keep the difference unless it borrowed
                rem_next = borrow ? rem_shift : alu_res[AW-1:0];
                dvd_next = {dvd_reg[TIME_WIDTH-2:0], 1'b0};
                cnt_next = cnt_reg - CNTW'(1);
            end
            ST_SUBR:
            begin
                // distance to the next period boundary; zero when exactly on one
                if (rem_reg != '0)
                    rem_next = alu_res[AW-1:0];
                use_rem_next = 1'b1;
                base_dl_next = 1'b0;
            end
            ST_ADD:
            begin
                deadline_next = sat_sum;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    running_next   = run_after;
                    if (cmd_reg == CMD_STOP)
                        remain_next = '0;
                    else
                        remain_next = remain_after;
                    out_valid_next = 1'b1;
                    unique case (cmd_reg)
                        CMD_START: ok_next = 1'b1;
                        CMD_STOP:  ok_next = running_reg;
                        default:   ok_next = fire_reg;
                    endcase
                    fired_next   = fire_reg;
                    nd_next      = run_after ? deadline_reg : '1;
                    run_out_next = run_after;
                end
            end
            default:
            begin
                fire_next = 1'b0;
            end
        endcase
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_STRICT;
            period_cfg_reg <= PERIOD_RESET;
            count_cfg_reg  <= COUNT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MODE:   mode_reg       <= cfg_data[1:0];
                REG_PERIOD: period_cfg_reg <= cfg_data[PERIOD_WIDTH-1:0];
                REG_COUNT:  count_cfg_reg  <= cfg_data[COUNT_WIDTH-1:0];
                default:    mode_reg       <= mode_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            running_reg   <= 1'b0;
            deadline_reg  <= '0;
            period_reg    <= '0;
            remain_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            running_reg   <= running_next;
            deadline_reg  <= deadline_next;
            period_reg    <= period_next;
            remain_reg    <= remain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        now_reg     <= now_next;
        fire_reg    <= fire_next;
        base_dl_reg <= base_dl_next;
        use_rem_reg <= use_rem_next;
        dvd_reg     <= dvd_next;
        rem_reg     <= rem_next;
        cnt_reg     <= cnt_next;
        ok_reg      <= ok_next;
        fired_reg   <= fired_next;
        nd_reg      <= nd_next;
        run_out_reg <= run_out_next;
    end

    assign out_valid     = out_valid_reg;
    assign ok            = ok_reg;
    assign fired         = fired_reg;
    assign next_deadline = nd_reg;
    assign running       = run_out_reg;

endmodule

`default_nettype wire

// File: rtl/prtm_checker.sv
// ----------------------------------------------------------------------------
// prtm_checker: port-level checks of the periodic timer
// Watches the top level's ports and flags inconsistent result words.
// ----------------------------------------------------------------------------
`default_nettype none

module prtm_checker #(
    parameter int TIME_WIDTH = prtm_pkg::TIME_WIDTH_DEF
) (
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  in_valid,
    input wire logic                  in_stall,
    input wire logic                  out_valid,
    input wire logic                  out_stall,
    input wire logic                  ok,
    input wire logic                  fired,
    input wire logic [TIME_WIDTH-1:0] next_deadline,
    input wire logic                  running
);

    // a stalled result word stays valid with its deadline held
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(next_deadline))
        else $error("stalled result word changed");

    // a stopped timer reports all ones
    a_stopped_deadline: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !running |-> (next_deadline == {TIME_WIDTH{1'b1}}))
        else $error("stopped timer reports a deadline");

    // an event always answers ok
    a_fired_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && fired |-> ok)
        else $error("fired without ok");

    // a taken word keeps the block busy in the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken again right after accept");

endmodule

bind periodic_timer_rearm_modes prtm_checker #(
    .TIME_WIDTH (TIME_WIDTH)
) u_prtm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .ok            (ok),
    .fired         (fired),
    .next_deadline (next_deadline),
    .running       (running)
);

`default_nettype wire
